>>> rtl/core/fps_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// fps_pkg
// Shared types, constants and the per-phase enable decode of the
// flight-phase sequencer.
// ---------------------------------------------------------------------------
package fps_pkg;

    localparam int unsigned AltW           = 16;
    localparam int unsigned PaddrW         = 2;
    localparam int unsigned PdataW         = 32;
    localparam logic [AltW-1:0] DeployReset = AltW'(200);

    // Register index of deploy_altitude
    localparam logic [PaddrW-1:0] RegDeployAlt = '0;

    typedef enum logic [3:0] {
        PH_INIT       = 4'd0,
        PH_IDLE       = 4'd1,
        PH_TESTING    = 4'd2,
        PH_READY      = 4'd3,
        PH_LAUNCH     = 4'd4,
        PH_MAX_HEIGHT = 4'd5,
        PH_DESCENT    = 4'd6,
        PH_PARA       = 4'd7,
        PH_LANDED     = 4'd8,
        PH_RECOVERY   = 4'd9,
        PH_SHUTDOWN   = 4'd10
    } t_phase;

    typedef struct packed {
        logic            sys_ok;
        logic            cmd_test;
        logic            tests_passed;
        logic            reboot_cmd;
        logic            accel_flag;
        logic [AltW-1:0] altitude;
        logic            apogee_flag;
        logic            pressure_flag;
        logic            recovered_flag;
        logic            power_off_cmd;
    } t_sample;

    typedef struct packed {
        logic pwr_en;
        logic gun_en;
        logic telemetry_en;
        logic beacon_en;
        logic location_en;
        logic logging_en;
        logic video_en;
        logic chute_fire;
        logic test_mode_on;
        logic ready_ind;
    } t_enables;

    typedef struct packed {
        t_phase   phase;
        t_enables en;
        logic     phase_changed;
    } t_result;

    // Moore enables, bit order: pwr gun tel beacon loc log video chute test ready
    function automatic t_enables phase_enables(input t_phase ph);
        t_enables e;
        case (ph)
            PH_INIT:       e = 10'b1110000000;
            PH_IDLE:       e = 10'b1010000000;
            PH_TESTING:    e = 10'b1110010010;
            PH_READY:      e = 10'b1010000001;
            PH_LAUNCH:     e = 10'b1011000000;
            PH_MAX_HEIGHT: e = 10'b1111000000;
            PH_DESCENT:    e = 10'b1111011000;
            PH_PARA:       e = 10'b1111111100;
            PH_LANDED:     e = 10'b1001100000;
            PH_RECOVERY:   e = 10'b1000000000;
            default:       e = '0;
        endcase
        return e;
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/fps_regs.sv
`default_nettype none
// ---------------------------------------------------------------------------
// fps_regs
// APB register file: deploy altitude threshold.
// ---------------------------------------------------------------------------
module fps_regs
    import fps_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [PaddrW-1:0] paddr,
    input  wire logic [PdataW-1:0] pwdata,
    output logic      [PdataW-1:0] prdata,
    output logic                   pready,
    output logic      [AltW-1:0]   o_deploy_alt
);

    logic [AltW-1:0] r_deploy_alt;
    logic            wr_en;

    // Single register, bits 15:0 at every address; byte lanes ignored
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deploy_alt <= DeployReset;
        end else if (wr_en) begin
            r_deploy_alt <= pwdata[AltW-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        case (paddr)
            RegDeployAlt: prdata = PdataW'(r_deploy_alt);
            default:      prdata = PdataW'(r_deploy_alt);
        endcase
    end

    assign o_deploy_alt = r_deploy_alt;

endmodule
`default_nettype wire

>>> rtl/core/fps_step.sv
`default_nettype none
// ---------------------------------------------------------------------------
// fps_step
// Next-phase decision and Moore enable decode for one sample beat.
// ---------------------------------------------------------------------------
module fps_step
    import fps_pkg::*;
(
    input  wire t_phase          i_cur,
    input  wire t_sample         i_smp,
    input  wire logic [AltW-1:0] i_deploy_alt,
    output t_result              o_res
);

    t_phase nxt;

    always_comb begin
        nxt = i_cur;
        case (i_cur)
            PH_INIT:       if (i_smp.sys_ok) nxt = PH_IDLE;
            PH_IDLE: begin
                // acceleration wins over a test command
                if (i_smp.accel_flag)    nxt = PH_LAUNCH;
                else if (i_smp.cmd_test) nxt = PH_TESTING;
            end
            PH_TESTING:    nxt = i_smp.tests_passed ? PH_READY : PH_INIT;
            PH_READY:      if (i_smp.reboot_cmd) nxt = PH_INIT;
            PH_LAUNCH:     if (i_smp.apogee_flag) nxt = PH_MAX_HEIGHT;
            PH_MAX_HEIGHT: if (i_smp.apogee_flag && i_smp.accel_flag) nxt = PH_DESCENT;
            PH_DESCENT:    if (i_smp.altitude <= i_deploy_alt) nxt = PH_PARA;
            PH_PARA:       if (i_smp.pressure_flag) nxt = PH_LANDED;
            PH_LANDED:     if (i_smp.recovered_flag) nxt = PH_RECOVERY;
            PH_RECOVERY:   if (i_smp.power_off_cmd) nxt = PH_SHUTDOWN;
            default:       nxt = i_cur;
        endcase
    end

    assign o_res.phase         = nxt;
    assign o_res.en            = phase_enables(nxt);
    assign o_res.phase_changed = (nxt != i_cur);

endmodule
`default_nettype wire

>>> rtl/core/flight_phase_sequencer.sv
`default_nettype none
// ---------------------------------------------------------------------------
// flight_phase_sequencer
// Rocket flight-phase sequencer: eleven phases, one step per sample beat.
// ---------------------------------------------------------------------------
// Each input beat is one sensor/command sample. It lands in an input
// register, the phase decode runs in the cycle after, and the result (new
// phase, ten Moore enables decoded from the new phase, and a changed flag)
// is captured in an output register. Throughput is one beat per cycle while
// the result side does not stall, set by the phase update through the phase
// register. The input side keeps accepting while a finished result waits,
// until both the input and output registers are full. Shutdown is terminal.
// The deploy threshold is written over APB at byte address 0 (any address
// reaches it; reset value 200) and must only change while no beat is
// in flight.
// ---------------------------------------------------------------------------
module flight_phase_sequencer
    import fps_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // APB configuration
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [PaddrW-1:0] paddr,
    input  wire logic [PdataW-1:0] pwdata,
    output logic      [PdataW-1:0] prdata,
    output logic                   pready,
    // sample channel
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic              i_sys_ok,
    input  wire logic              i_cmd_test,
    input  wire logic              i_tests_passed,
    input  wire logic              i_reboot_cmd,
    input  wire logic              i_accel_flag,
    input  wire logic [AltW-1:0]   i_altitude,
    input  wire logic              i_apogee_flag,
    input  wire logic              i_pressure_flag,
    input  wire logic              i_recovered_flag,
    input  wire logic              i_power_off_cmd,
    // result channel
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic      [3:0]        o_phase,
    output logic                   o_pwr_en,
    output logic                   o_gun_en,
    output logic                   o_telemetry_en,
    output logic                   o_beacon_en,
    output logic                   o_location_en,
    output logic                   o_logging_en,
    output logic                   o_video_en,
    output logic                   o_chute_fire,
    output logic                   o_test_mode_on,
    output logic                   o_ready_ind,
    output logic                   o_phase_changed
);

    logic [AltW-1:0] deploy_alt;
    t_sample         smp_in;
    t_result         step_res;

    logic    r_in_vld,  n_in_vld;
    t_sample r_in,      n_in;
    logic    r_out_vld, n_out_vld;
    t_result r_out,     n_out;
    t_phase  r_phase,   n_phase;

    logic in_take;
    logic advance;

    fps_regs u_regs (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_deploy_alt (deploy_alt)
    );

    fps_step u_step (
        .i_cur        (r_phase),
        .i_smp        (r_in),
        .i_deploy_alt (deploy_alt),
        .o_res        (step_res)
    );

    // Gather the sample ports into one word
    always_comb begin
        smp_in.sys_ok         = i_sys_ok;
        smp_in.cmd_test       = i_cmd_test;
        smp_in.tests_passed   = i_tests_passed;
        smp_in.reboot_cmd     = i_reboot_cmd;
        smp_in.accel_flag     = i_accel_flag;
        smp_in.altitude       = i_altitude;
        smp_in.apogee_flag    = i_apogee_flag;
        smp_in.pressure_flag  = i_pressure_flag;
        smp_in.recovered_flag = i_recovered_flag;
        smp_in.power_off_cmd  = i_power_off_cmd;
    end

    // Advance the held sample into the result register when that slot is
    // empty or drains this cycle; the phase register moves with it.
    assign advance    = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || advance;
    assign in_take    = i_in_valid && o_in_ready;

    always_comb begin
        n_in_vld  = r_in_vld;
        n_in      = r_in;
        n_out_vld = r_out_vld;
        n_out     = r_out;
        n_phase   = r_phase;
        if (advance) begin
            n_in_vld = 1'b0;
        end
        if (in_take) begin
            n_in_vld = 1'b1;
            n_in     = smp_in;
        end
        if (o_out_valid && i_out_ready) begin
            n_out_vld = 1'b0;
        end
        if (advance) begin
            n_out_vld = 1'b1;
            n_out     = step_res;
            n_phase   = step_res.phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_phase   <= PH_INIT;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
            r_phase   <= n_phase;
        end
        // payload registers: no reset
        r_in  <= n_in;
        r_out <= n_out;
    end

    assign o_out_valid     = r_out_vld;
    assign o_phase         = r_out.phase;
    assign o_pwr_en        = r_out.en.pwr_en;
    assign o_gun_en        = r_out.en.gun_en;
    assign o_telemetry_en  = r_out.en.telemetry_en;
    assign o_beacon_en     = r_out.en.beacon_en;
    assign o_location_en   = r_out.en.location_en;
    assign o_logging_en    = r_out.en.logging_en;
    assign o_video_en      = r_out.en.video_en;
    assign o_chute_fire    = r_out.en.chute_fire;
    assign o_test_mode_on  = r_out.en.test_mode_on;
    assign o_ready_ind     = r_out.en.ready_ind;
    assign o_phase_changed = r_out.phase_changed;

    // Shutdown never leaves
    a_shutdown_terminal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SHUTDOWN) |=> (r_phase == PH_SHUTDOWN))
        else $error("phase left shutdown");

    // A waiting result always shows the current phase
    a_out_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out.phase == r_phase))
        else $error("result phase differs from phase register");

    // Changed flag agrees with the phase step just taken
    a_changed_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> (r_out.phase_changed == (r_phase != $past(r_phase))))
        else $error("phase_changed does not match phase step");

    // Parachute fires only in deployment phase
    a_chute_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.en.chute_fire) |-> (r_out.phase == PH_PARA))
        else $error("chute fire outside deployment phase");

    // Phase step is at most one phase forward, back to init, or into launch
    a_step_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> ((r_phase == $past(r_phase)) || (r_phase == PH_INIT)
                     || (r_phase == PH_LAUNCH) || (r_phase == $past(r_phase) + 4'd1)))
        else $error("illegal phase jump");

endmodule
`default_nettype wire

>>> tb/flight_phase_sequencer_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// flight_phase_sequencer_tb
// Self-checking bench for the flight-phase sequencer. A queue of sensor
// samples feeds a bursty sender. A local phase predictor computes the
// expected phase, enables and changed flag per accepted beat. A monitor
// behind a stalling receiver checks each result field by field. The deploy
// threshold is reprogrammed over APB with no beat in flight and read back.
// ---------------------------------------------------------------------------
module flight_phase_sequencer_tb;
    import fps_pkg::*;

    localparam logic [PaddrW-1:0] DeployAltAddr = PaddrW'(4 * RegDeployAlt);
    localparam int unsigned       IdleLimit     = 2000;
    localparam int unsigned       MaxReports    = 40;

    // Clock, reset and APB
    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [PaddrW-1:0] paddr   = '0;
    logic [PdataW-1:0] pwdata  = '0;
    logic [PdataW-1:0] prdata;
    logic              pready;

    // Sample and result channels
    logic              i_in_valid  = 1'b0;
    logic              o_in_ready;
    t_sample           drv_s       = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [3:0]        o_phase;
    logic              o_pwr_en, o_gun_en, o_telemetry_en, o_beacon_en, o_location_en;
    logic              o_logging_en, o_video_en, o_chute_fire, o_test_mode_on, o_ready_ind;
    logic              o_phase_changed;

    // Samples waiting to go out, and predicted results the monitor waits for
    t_sample           sample_q[$];
    t_result           phase_expect_q[$];

    // Predictor state: tracks the block beat by beat
    t_phase            model_phase = PH_INIT;
    logic [AltW-1:0]   model_thr   = DeployReset;
    // Stimulus planning runs ahead of the driver on its own copy of the phase
    t_phase            plan_phase  = PH_INIT;

    int unsigned       mismatch_count = 0;
    int unsigned       idle_cycles    = 0;
    int unsigned       burst_left     = 0;
    int unsigned       gap_left       = 0;
    int unsigned       stall_win      = 0;
    int unsigned       stall_mode     = 0;
    logic [31:0]       cyc            = '0;

    t_phase            drv_next;
    t_result           drv_want;
    t_result           mon_want;
    t_enables          mon_got_en;

    string enable_names [10] = '{"pwr_en", "gun_en", "telemetry_en", "beacon_en",
                                 "location_en", "logging_en", "video_en", "chute_fire",
                                 "test_mode_on", "ready_ind"};

    wire in_fire  = i_in_valid && o_in_ready;
    wire out_fire = o_out_valid && i_out_ready;

    flight_phase_sequencer u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_sys_ok         (drv_s.sys_ok),
        .i_cmd_test       (drv_s.cmd_test),
        .i_tests_passed   (drv_s.tests_passed),
        .i_reboot_cmd     (drv_s.reboot_cmd),
        .i_accel_flag     (drv_s.accel_flag),
        .i_altitude       (drv_s.altitude),
        .i_apogee_flag    (drv_s.apogee_flag),
        .i_pressure_flag  (drv_s.pressure_flag),
        .i_recovered_flag (drv_s.recovered_flag),
        .i_power_off_cmd  (drv_s.power_off_cmd),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_phase          (o_phase),
        .o_pwr_en         (o_pwr_en),
        .o_gun_en         (o_gun_en),
        .o_telemetry_en   (o_telemetry_en),
        .o_beacon_en      (o_beacon_en),
        .o_location_en    (o_location_en),
        .o_logging_en     (o_logging_en),
        .o_video_en       (o_video_en),
        .o_chute_fire     (o_chute_fire),
        .o_test_mode_on   (o_test_mode_on),
        .o_ready_ind      (o_ready_ind),
        .o_phase_changed  (o_phase_changed)
    );

    always #5 i_clk = ~i_clk;

    // -----------------------------------------------------------------------
    // Phase predictor
    // -----------------------------------------------------------------------
    // One step per beat; shutdown and the unused codes hold forever.
    function automatic t_phase advance_phase(input t_phase cur, input t_sample s,
                                             input logic [AltW-1:0] thr);
        t_phase nxt;
        nxt = cur;
        case (cur)
            PH_INIT:       if (s.sys_ok) nxt = PH_IDLE;
            PH_IDLE: begin
                // Acceleration wins over a pending test command
                if (s.accel_flag)    nxt = PH_LAUNCH;
                else if (s.cmd_test) nxt = PH_TESTING;
            end
            PH_TESTING:    nxt = s.tests_passed ? PH_READY : PH_INIT;
            PH_READY:      if (s.reboot_cmd) nxt = PH_INIT;
            PH_LAUNCH:     if (s.apogee_flag) nxt = PH_MAX_HEIGHT;
            PH_MAX_HEIGHT: if (s.apogee_flag && s.accel_flag) nxt = PH_DESCENT;
            PH_DESCENT:    if (s.altitude <= thr) nxt = PH_PARA;
            PH_PARA:       if (s.pressure_flag) nxt = PH_LANDED;
            PH_LANDED:     if (s.recovered_flag) nxt = PH_RECOVERY;
            PH_RECOVERY:   if (s.power_off_cmd) nxt = PH_SHUTDOWN;
            default:       nxt = cur;
        endcase
        return nxt;
    endfunction

    // Moore enables as ranges over the phase order; codes past shutdown give zero
    function automatic t_enables decode_enables(input t_phase ph);
        t_enables e;
        e.pwr_en       = ph <= PH_RECOVERY;
        e.gun_en       = ph == PH_INIT || ph == PH_TESTING ||
                         (ph >= PH_MAX_HEIGHT && ph <= PH_PARA);
        e.telemetry_en = ph <= PH_PARA;
        e.beacon_en    = ph >= PH_LAUNCH && ph <= PH_LANDED;
        e.location_en  = ph == PH_PARA || ph == PH_LANDED;
        e.logging_en   = ph == PH_TESTING || ph == PH_DESCENT || ph == PH_PARA;
        e.video_en     = ph == PH_DESCENT || ph == PH_PARA;
        e.chute_fire   = ph == PH_PARA;
        e.test_mode_on = ph == PH_TESTING;
        e.ready_ind    = ph == PH_READY;
        return e;
    endfunction

    // -----------------------------------------------------------------------
    // Stimulus helpers
    // -----------------------------------------------------------------------
    // Random sample shaped to hold (go = 0) or advance (go = 1) the phase. Idle
    // never sees acceleration; launch is placed by hand; testing never holds.
    function automatic t_sample make_sample(input t_phase ph, input bit go);
        t_sample s;
        s = t_sample'({$urandom, $urandom});
        case (ph)
            PH_INIT:       s.sys_ok = go;
            PH_IDLE: begin
                s.accel_flag = 1'b0;
                s.cmd_test   = go;
            end
            PH_TESTING:    s.tests_passed = go;
            PH_READY:      s.reboot_cmd = go;
            PH_LAUNCH:     s.apogee_flag = go;
            PH_MAX_HEIGHT: begin
                if (go) begin
                    s.apogee_flag = 1'b1;
                    s.accel_flag  = 1'b1;
                end else if (s.apogee_flag && s.accel_flag) begin
                    if ($urandom_range(0, 1)) s.apogee_flag = 1'b0;
                    else                      s.accel_flag  = 1'b0;
                end
            end
            PH_DESCENT: begin
                if (go)
                    s.altitude = AltW'($urandom_range(0, int'(model_thr)));
                else if (model_thr != '1)
                    s.altitude = AltW'($urandom_range(int'(model_thr) + 1, 65535));
            end
            PH_PARA:       s.pressure_flag = go;
            PH_LANDED:     s.recovered_flag = go;
            PH_RECOVERY:   s.power_off_cmd = go;
            default:       ;
        endcase
        return s;
    endfunction

    task automatic queue_sample(input t_sample s);
        sample_q.push_back(s);
        plan_phase = advance_phase(plan_phase, s, model_thr);
    endtask

    // Sit in the current phase for a few beats, then move on
    task automatic hold_then_advance(input int unsigned n);
        repeat (n) queue_sample(make_sample(plan_phase, 1'b0));
        queue_sample(make_sample(plan_phase, 1'b1));
    endtask

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        if (mismatch_count < MaxReports)
            $display("[%0t] mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Wait until every queued beat has gone in and every result has come out,
    // then let the pipeline drain a little further.
    task automatic settle();
        @(negedge i_clk);
        while (sample_q.size() != 0 || i_in_valid || phase_expect_q.size() != 0)
            @(negedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic check_deploy_altitude();
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= DeployAltAddr;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[AltW-1:0] !== model_thr)
            flag_mismatch("deploy_altitude readback", prdata[AltW-1:0], model_thr);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_deploy_altitude(input logic [AltW-1:0] value);
        settle();
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= DeployAltAddr;
        pwdata  <= PdataW'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        // register takes the value at this edge
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        model_thr = value;
        check_deploy_altitude();
    endtask

    // -----------------------------------------------------------------------
    // Sender: bursts of beats with random gaps; predict on every accepted beat
    // -----------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            gap_left   <= 0;
            burst_left <= 0;
        end else begin
            if (in_fire) begin
                drv_next               = advance_phase(model_phase, drv_s, model_thr);
                drv_want.phase         = drv_next;
                drv_want.en            = decode_enables(drv_next);
                drv_want.phase_changed = drv_next != model_phase;
                phase_expect_q.push_back(drv_want);
                model_phase            = drv_next;
            end
            // Hold valid and payload until accepted; otherwise load the next beat
            if (!i_in_valid || in_fire) begin
                if (gap_left > 0) begin
                    gap_left   <= gap_left - 1;
                    i_in_valid <= 1'b0;
                end else if (sample_q.size() > 0) begin
                    drv_s      <= sample_q.pop_front();
                    i_in_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 24);
                        // a third of the bursts follow on with no gap at all
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // Receiver: stall pattern switches between always ready, coin flip,
    // one in four and alternate cycles, in windows of random length
    // -----------------------------------------------------------------------
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (stall_win == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_win  <= $urandom_range(8, 64);
        end else begin
            stall_win <= stall_win - 1;
        end
        case (stall_mode)
            0:       i_out_ready <= 1'b1;
            1:       i_out_ready <= 1'($urandom_range(0, 1));
            2:       i_out_ready <= cyc[1:0] == 2'd0;
            default: i_out_ready <= cyc[0];
        endcase
    end

    // -----------------------------------------------------------------------
    // Monitor: compare each result beat against the oldest prediction
    // -----------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && out_fire) begin
            if (phase_expect_q.size() == 0) begin
                flag_mismatch("unexpected result beat, phase", o_phase, 0);
            end else begin
                mon_want   = phase_expect_q.pop_front();
                mon_got_en = {o_pwr_en, o_gun_en, o_telemetry_en, o_beacon_en, o_location_en,
                              o_logging_en, o_video_en, o_chute_fire, o_test_mode_on,
                              o_ready_ind};
                if (o_phase !== mon_want.phase)
                    flag_mismatch("phase", o_phase, mon_want.phase);
                for (int b = 0; b < 10; b++) begin
                    if (mon_got_en[b] !== mon_want.en[b])
                        flag_mismatch(enable_names[9-b], mon_got_en[b], mon_want.en[b]);
                end
                if (o_phase_changed !== mon_want.phase_changed)
                    flag_mismatch("phase_changed", o_phase_changed, mon_want.phase_changed);
            end
        end
    end

    // Watchdog: drop the run if no beat moves on either channel for too long
    always @(posedge i_clk) begin
        if (in_fire || out_fire || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IdleLimit) begin
            $display("[%0t] no beat for %0d cycles", $realtime, IdleLimit);
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // -----------------------------------------------------------------------
    // Stimulus
    // -----------------------------------------------------------------------
    initial begin
        t_sample         s;
        bit              go;
        logic [AltW-1:0] mid;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // threshold must come out of reset at its default
        check_deploy_altitude();

        // Directed: every ground transition, with all-ones and all-zeros payloads
        s = '1; s.sys_ok = 1'b0;              queue_sample(s);  // init holds
        s = '0; s.sys_ok = 1'b1;              queue_sample(s);  // init -> idle
        s = '0;                               queue_sample(s);  // idle holds
        s = '1; s.accel_flag = 1'b0;          queue_sample(s);  // idle -> testing
        s = '0;                               queue_sample(s);  // self test fails
        queue_sample(make_sample(PH_INIT, 1'b1));
        queue_sample(make_sample(PH_IDLE, 1'b1));
        s = '1;                               queue_sample(s);  // self test passes
        s = '1; s.reboot_cmd = 1'b0;          queue_sample(s);  // ready holds
        s = '0; s.reboot_cmd = 1'b1;          queue_sample(s);  // reboot to init

        // Random ground loop: the flight phases can be visited only once per
        // run, so most of the traffic circles init, idle, testing and ready.
        for (int k = 0; k < 480; k++) begin
            case (k)
                60:  set_deploy_altitude('1);
                180: set_deploy_altitude('0);
                300: set_deploy_altitude(AltW'($urandom));
                420: set_deploy_altitude(DeployReset);
                default: ;
            endcase
            go = (plan_phase == PH_READY) ? ($urandom_range(0, 9) < 4)
                                          : ($urandom_range(0, 9) < 7);
            queue_sample(make_sample(plan_phase, go));
        end
        while (plan_phase != PH_IDLE)
            queue_sample(make_sample(plan_phase, 1'b1));

        // Flight: launch with a test command pending too
        s = make_sample(PH_IDLE, 1'b1);
        s.accel_flag = 1'b1;
        s.cmd_test   = 1'b1;
        queue_sample(s);

        s = '1; s.apogee_flag = 1'b0;         queue_sample(s);
        hold_then_advance($urandom_range(3, 12));

        // Max height needs apogee and acceleration together
        s = make_sample(PH_MAX_HEIGHT, 1'b0); s.apogee_flag = 1'b1; s.accel_flag = 1'b0;
        queue_sample(s);
        s = make_sample(PH_MAX_HEIGHT, 1'b0); s.apogee_flag = 1'b0; s.accel_flag = 1'b1;
        queue_sample(s);
        hold_then_advance($urandom_range(3, 12));

        // Descent: reprogram the threshold while the phase holds
        set_deploy_altitude('0);
        s = make_sample(PH_DESCENT, 1'b0); s.altitude = AltW'(1); queue_sample(s);
        s.altitude = '1;                                             queue_sample(s);
        repeat ($urandom_range(4, 10)) queue_sample(make_sample(PH_DESCENT, 1'b0));
        mid = AltW'($urandom_range(1000, 60000));
        set_deploy_altitude(mid);
        s = make_sample(PH_DESCENT, 1'b0); s.altitude = mid + 1'b1; queue_sample(s);
        repeat ($urandom_range(4, 10)) queue_sample(make_sample(PH_DESCENT, 1'b0));
        // top threshold: the altitude ceiling sits right at it and deploys
        set_deploy_altitude('1);
        s = make_sample(PH_DESCENT, 1'b1); s.altitude = '1; queue_sample(s);

        s = '1; s.pressure_flag = 1'b0;       queue_sample(s);
        hold_then_advance($urandom_range(3, 12));
        s = '1; s.recovered_flag = 1'b0;      queue_sample(s);
        hold_then_advance($urandom_range(3, 12));
        s = '1; s.power_off_cmd = 1'b0;       queue_sample(s);
        hold_then_advance($urandom_range(3, 12));

        // Shutdown is terminal: nothing may move it
        queue_sample('1);
        queue_sample('0);
        repeat (20) queue_sample(t_sample'({$urandom, $urandom}));

        settle();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/core/fps_pkg.sv
rtl/core/fps_regs.sv
rtl/core/fps_step.sv
rtl/core/flight_phase_sequencer.sv
tb/flight_phase_sequencer_tb.sv
